[design/eea_pkg.sv]
`timescale 1ns / 1ps

package eea_pkg;

  // Mode register codes
  localparam logic [2:0] MODE_MEAN = 3'd0;
  localparam logic [2:0] MODE_MIN  = 3'd1;
  localparam logic [2:0] MODE_MAX  = 3'd2;
  localparam logic [2:0] MODE_DEV  = 3'd3;
  localparam logic [2:0] MODE_L2   = 3'd4;

  localparam int unsigned RECIP_SHIFT = 24;

  typedef logic [24:0] recip_t;
  typedef recip_t recip_tab_t [256];

  // ceil(2^24 / n) for n = 1..256, indexed by n-1
  function automatic recip_tab_t build_recip();
    recip_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 25'(((64'd1 << RECIP_SHIFT) + 64'(i)) / 64'(i + 1));
    end
    return t;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

  // Fields carried down the update pipeline
  typedef struct packed {
    logic [15:0] x;
    logic [11:0] idx;
    logic [7:0]  vol;
    logic        first;
    logic [39:0] agg;
    logic [15:0] small_v;
    logic [15:0] m;
    logic        neg;
    logic [15:0] diff;
    recip_t      recip;
    logic [31:0] xx;
    logic [15:0] q;
    logic [15:0] m2;
    logic [15:0] e;
    logic [31:0] prod;
  } pipe_t;

  // Request handed to the root pipeline
  typedef struct packed {
    logic        l2;
    logic [11:0] idx;
    logic [39:0] val;
  } sq_req_t;

  typedef struct packed {
    logic [39:0] v;
    logic [39:0] r;
  } sq_vr_t;

  // One step of the bit-pair square root
  function automatic sq_vr_t sqrt_step(sq_vr_t a, int unsigned b);
    logic [39:0] bt;
    logic [39:0] t;
    sq_vr_t      o;
    bt = 40'(1) << b;
    t  = a.r + bt;
    o  = a;
    if (a.v >= t) begin
      o.v = a.v - t;
      o.r = (a.r >> 1) + bt;
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

endpackage

[design/eea_sqrt.sv]
`timescale 1ns / 1ps

module eea_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  eea_pkg::sq_req_t in_req_i,
  output logic             in_rdy_o,
  output logic             out_valid_o,
  output eea_pkg::sq_req_t out_req_o,
  input  logic             out_stall_i
);

  localparam int NST = 10;  // two root bits per stage

  typedef struct packed {
    logic           l2;
    logic [11:0]    idx;
    logic [39:0]    orig;
    eea_pkg::sq_vr_t vr;
  } sq_stage_t;

  logic      vld_q [NST];
  logic      rdy   [NST];
  sq_stage_t st_q  [NST];
  sq_stage_t st_d  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    sq_stage_t      src;
    logic           src_v;
    eea_pkg::sq_vr_t t1;

    if (s == 0) begin : g_first
      always_comb begin
        src.l2   = in_req_i.l2;
        src.idx  = in_req_i.idx;
        src.orig = in_req_i.val;
        src.vr.v = in_req_i.val;
        src.vr.r = '0;
      end
      assign src_v = in_valid_i;
    end else begin : g_next
      assign src   = st_q[s-1];
      assign src_v = vld_q[s-1];
    end

    if (s == NST - 1) begin : g_last
      assign rdy[s] = !vld_q[s] || !out_stall_i;
    end else begin : g_mid
      assign rdy[s] = !vld_q[s] || rdy[s+1];
    end

    // two root steps
    always_comb begin
      st_d[s]    = src;
      t1         = eea_pkg::sqrt_step(src.vr, 38 - 4 * s);
      st_d[s].vr = eea_pkg::sqrt_step(t1, 36 - 4 * s);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && src_v) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign in_rdy_o      = rdy[0];
  assign out_valid_o   = vld_q[NST-1];
  assign out_req_o.l2  = st_q[NST-1].l2;
  assign out_req_o.idx = st_q[NST-1].idx;
  assign out_req_o.val = st_q[NST-1].l2 ? st_q[NST-1].vr.r : st_q[NST-1].orig;

endmodule

[design/elementwise_ensemble_aggregator.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_stall_o   sample_i, element_index_i, volume_number_i
// out       output     out_valid_o/out_stall_i aggregate_o, element_out_o
// cfg       input      cfg_we_i                cfg_wdata_i (mode)
//
// One request per cycle while nothing stalls; 6 update stages, then 10 root stages.
// A request whose element is still in the six update stages waits at the input until the
// earlier update is written to the element store.
// Reset clears the valid bits and sets mode to mean; the element stores are not cleared.
// A stalled output holds its stage; earlier stages keep filling bubbles and take requests while one is left.

module elementwise_ensemble_aggregator #(
  parameter int ELEMENTS    = 4096,
  parameter int MAX_VOLUMES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_i,
  input  logic [11:0] element_index_i,
  input  logic [7:0]  volume_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [39:0] aggregate_o,
  output logic [11:0] element_out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i
);

  localparam int IW   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int VCAP = (MAX_VOLUMES - 1 > 255) ? 255 : MAX_VOLUMES - 1;
  localparam int NPS  = 6;
  localparam int SA = 0, SB = 1, SC = 2, SD = 3, SE = 4, SF = 5;

  logic [2:0] mode_q;

  logic           vld_q [NPS];
  logic           rdy   [NPS];
  eea_pkg::pipe_t st_q  [NPS];
  eea_pkg::pipe_t st_d  [NPS];

  logic [39:0] agg_mem  [ELEMENTS];
  logic [15:0] mean_mem [ELEMENTS];
  logic [39:0] rd_agg_q;
  logic [15:0] rd_mean_q;

  logic [31:0] rem;
  logic [11:0] idx_in;
  logic        hazard;
  logic        in_accept;
  logic [40:0] qprod;
  logic [40:0] sum_dev;
  logic [40:0] sum_sq;
  logic [39:0] new_agg;
  logic [15:0] new_mean;
  logic        wr_en;

  eea_pkg::sq_req_t sq_in;
  eea_pkg::sq_req_t sq_out;
  logic             sq_rdy;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= eea_pkg::MODE_MEAN;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Index modulo ELEMENTS by restoring subtraction
  always_comb begin
    rem = 32'(element_index_i);
    for (int k = 11; k >= 0; k--) begin
      if (rem >= (32'(ELEMENTS) << k)) begin
        rem = rem - (32'(ELEMENTS) << k);
      end
    end
    idx_in = rem[11:0];
  end

  // Same element still in flight: hold the request
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NPS; k++) begin
      if (vld_q[k] && st_q[k].idx == idx_in) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !rdy[SA] || hazard;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Ready chain
  always_comb begin
    rdy[SF] = !vld_q[SF] || sq_rdy;
    for (int k = NPS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  // Stage A: capture
  always_comb begin
    st_d[SA]       = '0;
    st_d[SA].x     = sample_i;
    st_d[SA].idx   = idx_in;
    st_d[SA].vol   = (volume_number_i > 8'(VCAP)) ? 8'(VCAP) : volume_number_i;
    st_d[SA].first = (volume_number_i == 8'd0);
  end

  // Stage B: store read (data lands in rd_*_q)
  assign st_d[SB] = st_q[SA];

  // Stage C: base value, deviation, reciprocal, square
  always_comb begin
    st_d[SC]         = st_q[SB];
    st_d[SC].agg     = rd_agg_q;
    st_d[SC].small_v = (rd_agg_q[39:16] != '0) ? 16'hFFFF : rd_agg_q[15:0];
    st_d[SC].m       = (mode_q == eea_pkg::MODE_DEV) ? rd_mean_q : st_d[SC].small_v;
    st_d[SC].neg     = st_q[SB].x < st_d[SC].m;
    st_d[SC].diff    = st_d[SC].neg ? (st_d[SC].m - st_q[SB].x) : (st_q[SB].x - st_d[SC].m);
    st_d[SC].recip   = eea_pkg::RECIP_TAB[st_q[SB].vol];
    st_d[SC].xx      = 32'(st_q[SB].x) * 32'(st_q[SB].x);
  end

  // Stage D: quotient by reciprocal
  always_comb begin
    st_d[SD]   = st_q[SC];
    qprod      = 41'(st_q[SC].diff) * 41'(st_q[SC].recip);
    st_d[SD].q = qprod[39:24];
  end

  // Stage E: new mean and second deviation
  always_comb begin
    st_d[SE]    = st_q[SD];
    st_d[SE].m2 = st_q[SD].neg ? (st_q[SD].m - st_q[SD].q) : (st_q[SD].m + st_q[SD].q);
    st_d[SE].e  = st_q[SD].diff - st_q[SD].q;
  end

  // Stage F: deviation product
  always_comb begin
    st_d[SF]      = st_q[SE];
    st_d[SF].prod = 32'(st_q[SE].diff) * 32'(st_q[SE].e);
  end

  // Update from stage F
  always_comb begin
    sum_dev  = 41'(st_q[SF].agg) + 41'(st_q[SF].prod);
    sum_sq   = 41'(st_q[SF].agg) + 41'(st_q[SF].xx);
    new_mean = st_q[SF].first ? st_q[SF].x : st_q[SF].m2;
    unique case (mode_q)
      eea_pkg::MODE_MEAN: new_agg = 40'(st_q[SF].first ? st_q[SF].x : st_q[SF].m2);
      eea_pkg::MODE_MIN:
        new_agg = 40'((st_q[SF].first || st_q[SF].x < st_q[SF].small_v) ?
                      st_q[SF].x : st_q[SF].small_v);
      eea_pkg::MODE_MAX:
        new_agg = 40'((st_q[SF].first || st_q[SF].x > st_q[SF].small_v) ?
                      st_q[SF].x : st_q[SF].small_v);
      eea_pkg::MODE_DEV:
        new_agg = st_q[SF].first ? 40'd0 : (sum_dev[40] ? '1 : sum_dev[39:0]);
      eea_pkg::MODE_L2:
        new_agg = st_q[SF].first ? 40'(st_q[SF].xx) : (sum_sq[40] ? '1 : sum_sq[39:0]);
      default: new_agg = st_q[SF].agg;
    endcase
  end

  assign wr_en = vld_q[SF] && sq_rdy;

  // Element stores
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      agg_mem[IW'(st_q[SF].idx)] <= new_agg;
      if (mode_q == eea_pkg::MODE_DEV) begin
        mean_mem[IW'(st_q[SF].idx)] <= new_mean;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SB] && vld_q[SA]) begin
      rd_agg_q  <= agg_mem[IW'(st_q[SA].idx)];
      rd_mean_q <= mean_mem[IW'(st_q[SA].idx)];
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NPS; k++) vld_q[k] <= 1'b0;
    end else begin
      if (rdy[SA]) vld_q[SA] <= in_accept;
      for (int k = 1; k < NPS; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Pipeline data
  always_ff @(posedge clk_i) begin
    if (in_accept) st_q[SA] <= st_d[SA];
    for (int k = 1; k < NPS; k++) begin
      if (rdy[k] && vld_q[k-1]) st_q[k] <= st_d[k];
    end
  end

  // Root pipeline and output
  assign sq_in.l2  = (mode_q == eea_pkg::MODE_L2);
  assign sq_in.idx = st_q[SF].idx;
  assign sq_in.val = new_agg;

  eea_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_q[SF]),
    .in_req_i    (sq_in),
    .in_rdy_o    (sq_rdy),
    .out_valid_o (out_valid_o),
    .out_req_o   (sq_out),
    .out_stall_i (out_stall_i)
  );

  assign aggregate_o   = sq_out.val;
  assign element_out_o = sq_out.idx;

  // Assertions
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> vld_q[SA])
    else $error("accepted request missing from stage A");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SD] |-> (st_q[SD].q <= st_q[SD].diff))
    else $error("reciprocal quotient exceeds deviation");

  a_small_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[SF] && (mode_q == eea_pkg::MODE_MEAN || mode_q == eea_pkg::MODE_MIN ||
                   mode_q == eea_pkg::MODE_MAX)) |-> (new_agg[39:16] == '0))
    else $error("mean/min/max aggregate wider than 16 bits");

endmodule
